[hw/rtl/tlfm_pkg.sv]
// ----------------------------------------------------------------------------
// tlfm_pkg
// Shared types and constants of the tank level frame monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfm_pkg;

  // frame layout
  localparam logic [7:0] FrameHeader = 8'hFF;
  localparam int unsigned RangeMinMm = 300;
  localparam int unsigned RangeMaxMm = 4500;
  localparam int unsigned StuckBandMm = 5;
  localparam int unsigned LevelFull = 1000;

  // (distance - offset) * 1000 stays below 2^23 for in-range distances
  localparam int unsigned DivW = 23;
  localparam int unsigned HeightW = 14;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] RegTankHeight = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSensorOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChangeDistance = 3'd2;
  localparam logic [CfgIdxW-1:0] RegChangeLevel = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStuckLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvalidLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAttemptLimit = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    POS_HUNT  = 2'd0,
    POS_HIGH  = 2'd1,
    POS_LOW   = 2'd2,
    POS_CHECK = 2'd3
  } frame_pos_e;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_LOAD   = 2'd1,
    ST_DIVIDE = 2'd2,
    ST_FINISH = 2'd3
  } mon_state_e;

endpackage

`default_nettype wire

[hw/rtl/tlfm_div.sv]
// ----------------------------------------------------------------------------
// tlfm_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tlfm_pkg::DivW-1:0]    dividend_i,
  input  wire logic [tlfm_pkg::HeightW-1:0] divisor_i,
  output logic                              done_o,
  output logic [tlfm_pkg::DivW-1:0]         quotient_o
);
  import tlfm_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [HeightW-1:0] rem_q, rem_d;
  logic [DivW-1:0]    dq_q, dq_d;   // dividend shifts out, quotient shifts in
  logic [HeightW:0]   part;
  logic               ge;

  always_comb begin
    part = {rem_q, dq_q[DivW-1]};
    ge   = part >= {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW - 1);
      rem_d  = '0;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? HeightW'(part - {1'b0, divisor_i}) : part[HeightW-1:0];
      dq_d  = {dq_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

[hw/rtl/tank_level_frame_monitor.sv]
// ----------------------------------------------------------------------------
// tank_level_frame_monitor
// Parses sensor UART frames, checks them, derives fill level and health flags.
// ----------------------------------------------------------------------------
//  channel | signals                             | dir | word
//  --------+-------------------------------------+-----+----------------------
//  in      | in_valid_i / in_stall_o             | in  | rx_byte_i
//  out     | out_valid_o / out_stall_i           | out | status, distance, level,
//          |                                     |     | change, reinit, restart
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i  | in  | one register per write
//
// Header and data bytes are not held off in the run state. A bad frame's
// result is ready the cycle after its checksum byte. A valid frame holds the
// input through load, the bit steps of the serial level divider, done and finish.
// The checksum byte is also held off while the previous result is not taken.
// Reset (async, active low) clears the counters, the last-sent values and the
// hunt state; configuration returns to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_level_frame_monitor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          status_o,
  output logic [15:0]                         distance_mm_o,
  output logic [9:0]                          level_permille_o,
  output logic                                significant_change_o,
  output logic                                reinit_request_o,
  output logic                                restart_request_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tlfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tlfm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import tlfm_pkg::*;

  // configuration
  logic [13:0] height_q, offset_q;
  logic [12:0] chg_dist_q;
  logic [9:0]  chg_lvl_q;
  logic [5:0]  stuck_lim_q, inval_lim_q;
  logic [2:0]  att_lim_q;

  mon_state_e  state_q, state_d;
  frame_pos_e  pos_q, pos_d;
  logic [7:0]  hi_q, hi_d, lo_q, lo_d;
  logic [15:0] prev_q, prev_d;
  logic [5:0]  rep_q, rep_d;
  logic [2:0]  att_q, att_d;
  logic [15:0] sent_dist_q, sent_dist_d;
  logic [9:0]  sent_lvl_q, sent_lvl_d;
  logic        first_q, first_d;

  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [15:0] dist_q, dist_d;
  logic [9:0]  lvl_q, lvl_d;
  logic        sig_q, sig_d;
  logic        reinit_q, reinit_d;
  logic        restart_q, restart_d;

  logic                in_acc;
  logic                div_start, div_done;
  logic [DivW-1:0]     dividend, quotient;
  logic [HeightW-1:0]  divisor;
  logic [7:0]          sum8;
  logic [15:0]         frame_dist;
  status_e             frame_status;
  logic [5:0]          rep_inc;
  logic [2:0]          att_inc;
  logic [15:0]         d_prev, d_sent;
  logic [9:0]          new_lvl, d_lvl;

  function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
    abs_diff16 = (a > b) ? (a - b) : (b - a);
  endfunction

  // ---- configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= 14'd2000;
      offset_q    <= 14'd0;
      chg_dist_q  <= 13'd20;
      chg_lvl_q   <= 10'd10;
      stuck_lim_q <= 6'd15;
      inval_lim_q <= 6'd5;
      att_lim_q   <= 3'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTankHeight:     height_q    <= cfg_wdata_i;
        RegSensorOffset:   offset_q    <= cfg_wdata_i;
        RegChangeDistance: chg_dist_q  <= cfg_wdata_i[12:0];
        RegChangeLevel:    chg_lvl_q   <= cfg_wdata_i[9:0];
        RegStuckLimit:     stuck_lim_q <= cfg_wdata_i[5:0];
        RegInvalidLimit:   inval_lim_q <= cfg_wdata_i[5:0];
        RegAttemptLimit:   att_lim_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // ---- sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_acc && pos_q == POS_CHECK && frame_status == STATUS_OK) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_RUN;
      default:   state_d = ST_RUN;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    case (state_q)
      ST_RUN:  in_stall_o = out_valid_q && (pos_q == POS_CHECK);
      ST_LOAD: div_start  = 1'b1;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // ---- frame checks
  always_comb begin
    sum8       = FrameHeader + hi_q + lo_q;
    frame_dist = {hi_q, lo_q};
    if (sum8 != rx_byte_i) begin
      frame_status = STATUS_CHECKSUM;
    end else if (frame_dist < 16'(RangeMinMm) || frame_dist > 16'(RangeMaxMm)) begin
      frame_status = STATUS_RANGE;
    end else begin
      frame_status = STATUS_OK;
    end
    rep_inc = (rep_q == '1) ? rep_q : rep_q + 1'b1;
    att_inc = (att_q == '1) ? att_q : att_q + 1'b1;
    d_prev  = abs_diff16(frame_dist, prev_q);
  end

  // ---- divider operands; a distance short of the offset reads as full
  always_comb begin
    logic [12:0] span;
    span     = (dist_q > {2'b00, offset_q}) ? 13'(dist_q - {2'b00, offset_q}) : '0;
    dividend = DivW'(span) * DivW'(LevelFull);
    divisor  = (height_q == '0) ? HeightW'(1) : height_q;
  end

  tlfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    new_lvl = (quotient >= DivW'(LevelFull)) ? '0 : 10'(LevelFull) - quotient[9:0];
    d_sent  = abs_diff16(dist_q, sent_dist_q);
    d_lvl   = (new_lvl > sent_lvl_q) ? (new_lvl - sent_lvl_q) : (sent_lvl_q - new_lvl);
  end

  // ---- state update
  always_comb begin
    pos_d       = pos_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    prev_d      = prev_q;
    rep_d       = rep_q;
    att_d       = att_q;
    sent_dist_d = sent_dist_q;
    sent_lvl_d  = sent_lvl_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    dist_d      = dist_q;
    lvl_d       = lvl_q;
    sig_d       = sig_q;
    reinit_d    = reinit_q;
    restart_d   = restart_q;

    if (in_acc) begin
      case (pos_q)
        POS_HUNT: if (rx_byte_i == FrameHeader) pos_d = POS_HIGH;
        POS_HIGH: begin
          hi_d  = rx_byte_i;
          pos_d = POS_LOW;
        end
        POS_LOW: begin
          lo_d  = rx_byte_i;
          pos_d = POS_CHECK;
        end
        POS_CHECK: begin
          pos_d     = POS_HUNT;
          status_d  = frame_status;
          dist_d    = frame_dist;
          lvl_d     = '0;
          sig_d     = 1'b0;
          reinit_d  = 1'b0;
          restart_d = 1'b0;
          if (frame_status != STATUS_OK) begin
            out_valid_d = 1'b1;
            rep_d       = rep_inc;
            if (rep_inc >= inval_lim_q) begin
              reinit_d = 1'b1;
              rep_d    = '0;
            end
          end else begin
            prev_d = frame_dist;
            if (d_prev < 16'(StuckBandMm)) begin
              rep_d = rep_inc;
              if (rep_inc >= stuck_lim_q) begin
                reinit_d = 1'b1;
                rep_d    = '0;
                att_d    = att_inc;
                if (att_inc >= att_lim_q) begin
                  restart_d = 1'b1;
                  att_d     = '0;
                end
              end
            end else begin
              rep_d = '0;
              att_d = '0;
            end
          end
        end
        default: pos_d = POS_HUNT;
      endcase
    end

    if (state_q == ST_FINISH) begin
      out_valid_d = 1'b1;
      lvl_d       = new_lvl;
      if (first_q || d_sent >= {3'b000, chg_dist_q} || d_lvl >= chg_lvl_q) begin
        sig_d       = 1'b1;
        sent_dist_d = dist_q;
        sent_lvl_d  = new_lvl;
        first_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      pos_q       <= POS_HUNT;
      prev_q      <= '0;
      rep_q       <= '0;
      att_q       <= '0;
      sent_dist_q <= '0;
      sent_lvl_q  <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      rep_q       <= rep_d;
      att_q       <= att_d;
      sent_dist_q <= sent_dist_d;
      sent_lvl_q  <= sent_lvl_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    status_q  <= status_d;
    dist_q    <= dist_d;
    lvl_q     <= lvl_d;
    sig_q     <= sig_d;
    reinit_q  <= reinit_d;
    restart_q <= restart_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign distance_mm_o        = dist_q;
  assign level_permille_o     = lvl_q;
  assign significant_change_o = sig_q;
  assign reinit_request_o     = reinit_q;
  assign restart_request_o    = restart_q;

`ifndef SYNTHESIS
  a_no_word_while_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_DIVIDE) |-> !out_valid_q)
    else $error("result word pending during level divide");

  a_done_in_divide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVIDE)
    else $error("divider finished outside divide state");

  a_bad_frame_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |->
      (level_permille_o == '0 && !significant_change_o && !restart_request_o))
    else $error("bad frame carries level, change or restart");

  a_restart_has_reinit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restart_request_o) |-> reinit_request_o)
    else $error("restart without reinit");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_permille_o <= 10'(LevelFull))
    else $error("level above full scale");
`endif

endmodule

`default_nettype wire
